[src/pbnu_pkg.sv]
// Shared constants, register codes and types of the packet block nibble unpacker.
`default_nettype none

package pbnu_pkg;

    // Default geometry of one packet block
    localparam int HEADER_LEN_DEF      = 2;
    localparam int PFB_COUNT_DEF       = 4;
    localparam int TIMES_PER_GROUP_DEF = 500;

    // Field widths
    localparam int WORD_W   = 16;
    localparam int OFFSET_W = 32;
    localparam int STRIDE_W = 23;
    localparam int PFB_W    = 4;
    localparam int SAMPLE_W = 4;

    // Counter widths
    localparam int POS_W   = 8;
    localparam int FINE_W  = 2;
    localparam int PAIR_W  = 5;
    localparam int TIME_W  = 9;
    localparam int GROUP_W = 2;

    // Payload words per packet: 4 fine channels of 32 station pairs
    localparam int PAYLOAD_WORDS = 128;

    // Offset steps that do not depend on the filterbank count
    localparam int PFB_STEP  = 128;
    localparam int PAIR_STEP = 4;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PFB_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PACKED_MODE = 2'd2;

    // One classified payload word with its position in the block
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [FINE_W-1:0]  fine;
        logic [PAIR_W-1:0]  pair;
        logic [TIME_W-1:0]  tstep;
        logic [GROUP_W-1:0] group;
        logic               last;
    } t_entry;

    // Configuration registers
    typedef struct packed {
        logic [STRIDE_W-1:0] time_stride;
        logic [PFB_W-1:0]    pfb_index;
        logic                packed_mode;
    } t_cfg;

endpackage

`default_nettype wire

[src/pbnu_if.sv]
// Channel interfaces of the packet block nibble unpacker: input words, config writes, results.
`default_nettype none

interface pbnu_in_if import pbnu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface pbnu_cfg_if import pbnu_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pbnu_out_if import pbnu_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OFFSET_W-1:0]        byte_offset;
    logic signed [SAMPLE_W-1:0] sample_zero;
    logic signed [SAMPLE_W-1:0] sample_one;
    logic signed [SAMPLE_W-1:0] sample_two;
    logic signed [SAMPLE_W-1:0] sample_three;
    logic [WORD_W-1:0]          packed_word;
    logic                       block_last;

    modport source (output valid, output byte_offset, output sample_zero, output sample_one,
                    output sample_two, output sample_three, output packed_word,
                    output block_last, input ready);
    modport sink   (input valid, input byte_offset, input sample_zero, input sample_one,
                    input sample_two, input sample_three, input packed_word,
                    input block_last, output ready);
endinterface

`default_nettype wire

[src/packet_block_nibble_unpacker_unit.sv]
// Packet block nibble unpacker: top level with configuration registers.
// A payload word reaches o_out through the queue and the stage 1 and stage 2 registers.
// Throughput: one word per cycle while o_out is ready; header and checksum words give no result.
// The rate is set by the input and output handshakes; the back end multiplier is fully pipelined.
// Reset clears the packet counters, the queue, the pipeline valids and all
// configuration registers to zero; no clearing pass, ready right after reset.
`default_nettype none

module packet_block_nibble_unpacker_unit import pbnu_pkg::*; #(
    parameter int HEADER_LEN      = HEADER_LEN_DEF,
    parameter int PFB_COUNT       = PFB_COUNT_DEF,
    parameter int TIMES_PER_GROUP = TIMES_PER_GROUP_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pbnu_in_if.sink    i_in,
    pbnu_cfg_if.sink   i_cfg,
    pbnu_out_if.source o_out
);

    t_cfg   r_cfg;
    t_entry w_front_entry;
    t_entry w_fifo_entry;
    logic   w_push;
    logic   w_full;
    logic   w_fifo_valid;
    logic   w_pop;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TIME_STRIDE: r_cfg.time_stride <= i_cfg.data[STRIDE_W-1:0];
                REG_PFB_INDEX:   r_cfg.pfb_index   <= i_cfg.data[PFB_W-1:0];
                REG_PACKED_MODE: r_cfg.packed_mode <= i_cfg.data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign i_in.ready = !w_full;

    pbnu_front #(
        .HEADER_LEN      (HEADER_LEN),
        .TIMES_PER_GROUP (TIMES_PER_GROUP)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in.valid && i_in.ready),
        .i_word   (i_in.word),
        .o_push   (w_push),
        .o_entry  (w_front_entry)
    );

    pbnu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_fifo_valid),
        .o_entry (w_fifo_entry)
    );

    pbnu_back #(
        .PFB_COUNT (PFB_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fifo_valid),
        .i_entry (w_fifo_entry),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[src/pbnu_front.sv]
// Front end: tracks packet position, drops header and checksum words, tags payload words.
`default_nettype none

module pbnu_front import pbnu_pkg::*; #(
    parameter int HEADER_LEN      = HEADER_LEN_DEF,
    parameter int TIMES_PER_GROUP = TIMES_PER_GROUP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [WORD_W-1:0] i_word,
    output logic                   o_push,
    output t_entry                 o_entry
);

    localparam logic [POS_W-1:0]   HDR_END   = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0]   PAY_END   = POS_W'(HEADER_LEN + PAYLOAD_WORDS);
    localparam logic [TIME_W:0]    TIME_END  = (TIME_W + 1)'(TIMES_PER_GROUP);
    localparam logic [FINE_W-1:0]  FINE_LAST = '1;
    localparam logic [PAIR_W-1:0]  PAIR_LAST = '1;
    localparam logic [GROUP_W-1:0] GROUP_LAST = '1;

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [FINE_W-1:0]  r_fine,  n_fine;
    logic [PAIR_W-1:0]  r_pair,  n_pair;
    logic [TIME_W-1:0]  r_time,  n_time;
    logic [GROUP_W-1:0] r_group, n_group;

    logic w_is_hdr;
    logic w_is_chk;
    logic w_is_pay;
    logic w_time_end;

    // Word classification
    assign w_is_hdr   = r_pos < HDR_END;
    assign w_is_chk   = r_pos >= PAY_END;
    assign w_is_pay   = !w_is_hdr && !w_is_chk;
    assign w_time_end = ({1'b0, r_time} + 1'b1) >= TIME_END;

    // Counter updates
    always_comb begin
        n_pos   = r_pos;
        n_fine  = r_fine;
        n_pair  = r_pair;
        n_time  = r_time;
        n_group = r_group;
        if (i_accept) begin
            if (w_is_chk) begin
                n_pos = '0;
                if (w_time_end) begin
                    n_time  = '0;
                    n_group = r_group + 1'b1;
                end else begin
                    n_time = r_time + 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
            if (w_is_pay) begin
                n_pair = r_pair + 1'b1;
                if (r_pair == PAIR_LAST) begin
                    n_fine = r_fine + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fine  <= '0;
            r_pair  <= '0;
            r_time  <= '0;
            r_group <= '0;
        end else begin
            r_pos   <= n_pos;
            r_fine  <= n_fine;
            r_pair  <= n_pair;
            r_time  <= n_time;
            r_group <= n_group;
        end
    end

    // Tagged payload beat toward the queue
    assign o_push        = i_accept && w_is_pay;
    assign o_entry.word  = i_word;
    assign o_entry.fine  = r_fine;
    assign o_entry.pair  = r_pair;
    assign o_entry.tstep = r_time;
    assign o_entry.group = r_group;
    assign o_entry.last  = (r_group == GROUP_LAST) && w_time_end &&
                           (r_fine == FINE_LAST) && (r_pair == PAIR_LAST);

endmodule

`default_nettype wire

[src/pbnu_fifo.sv]
// Short queue of tagged payload words between front and back.
`default_nettype none

module pbnu_fifo import pbnu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_entry
);

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;

    assign o_full  = r_count == FIFO_CW'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/pbnu_back.sv]
// Back end: offset multiply, offset sum and sample unpack, with a registered result beat.
`default_nettype none

module pbnu_back import pbnu_pkg::*; #(
    parameter int PFB_COUNT = PFB_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_entry      i_entry,
    output logic             o_pop,
    input  wire t_cfg        i_cfg,
    pbnu_out_if.source       o_out
);

    localparam logic [OFFSET_W-1:0] GROUP_STEP = OFFSET_W'(512 * PFB_COUNT);
    localparam logic [OFFSET_W-1:0] FINE_STEP  = OFFSET_W'(128 * PFB_COUNT);
    localparam int PROD_W = TIME_W + STRIDE_W;

    // Stage 1: product and position term
    logic                r1_valid;
    logic [OFFSET_W-1:0] r1_prod;
    logic [OFFSET_W-1:0] r1_base;
    logic [WORD_W-1:0]   r1_word;
    logic                r1_last;

    // Stage 2: result beat
    logic                       r2_valid;
    logic [OFFSET_W-1:0]        r2_offset;
    logic signed [SAMPLE_W-1:0] r2_s0;
    logic signed [SAMPLE_W-1:0] r2_s1;
    logic signed [SAMPLE_W-1:0] r2_s2;
    logic signed [SAMPLE_W-1:0] r2_s3;
    logic [WORD_W-1:0]          r2_packed;
    logic                       r2_last;

    logic                w_s1_en;
    logic                w_s2_en;
    logic [PROD_W-1:0]   w_prod;
    logic [OFFSET_W-1:0] w_base;
    logic [OFFSET_W-1:0] w_offset;

    // Stall chain
    assign w_s2_en = !r2_valid || o_out.ready;
    assign w_s1_en = !r1_valid || w_s2_en;
    assign o_pop   = i_valid && w_s1_en;

    assign w_prod = PROD_W'(i_entry.tstep) * PROD_W'(i_cfg.time_stride);
    assign w_base = OFFSET_W'(i_entry.group) * GROUP_STEP
                  + OFFSET_W'(i_entry.fine) * FINE_STEP
                  + OFFSET_W'(i_cfg.pfb_index) * OFFSET_W'(PFB_STEP)
                  + OFFSET_W'(i_entry.pair) * OFFSET_W'(PAIR_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r1_prod <= OFFSET_W'(w_prod);
            r1_base <= w_base;
            r1_word <= i_entry.word;
            r1_last <= i_entry.last;
        end
    end

    // Packed mode halves both terms; the position term is always a multiple of four
    assign w_offset = i_cfg.packed_mode ? (r1_prod >> 1) + (r1_base >> 1)
                                        : r1_prod + r1_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_s2_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en) begin
            r2_offset <= w_offset;
            r2_last   <= r1_last;
            if (i_cfg.packed_mode) begin
                r2_s0     <= '0;
                r2_s1     <= '0;
                r2_s2     <= '0;
                r2_s3     <= '0;
                r2_packed <= r1_word;
            end else begin
                r2_s0     <= r1_word[3:0];
                r2_s1     <= r1_word[7:4];
                r2_s2     <= r1_word[11:8];
                r2_s3     <= r1_word[15:12];
                r2_packed <= '0;
            end
        end
    end

    assign o_out.valid        = r2_valid;
    assign o_out.byte_offset  = r2_offset;
    assign o_out.sample_zero  = r2_s0;
    assign o_out.sample_one   = r2_s1;
    assign o_out.sample_two   = r2_s2;
    assign o_out.sample_three = r2_s3;
    assign o_out.packed_word  = r2_packed;
    assign o_out.block_last   = r2_last;

endmodule

`default_nettype wire

[src/pbnu_checker.sv]
// Port-level checks of the packet block nibble unpacker and their bind to the top level.
`default_nettype none

module pbnu_checker import pbnu_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [OFFSET_W-1:0]        i_out_offset,
    input wire logic signed [SAMPLE_W-1:0] i_out_s0,
    input wire logic signed [SAMPLE_W-1:0] i_out_s1,
    input wire logic signed [SAMPLE_W-1:0] i_out_s2,
    input wire logic signed [SAMPLE_W-1:0] i_out_s3,
    input wire logic [WORD_W-1:0]          i_out_packed,
    input wire logic                       i_out_last
);

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Input only backs up when a result is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // A passed-through word never comes with unpacked samples
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_packed != '0) |->
        (i_out_s0 == '0 && i_out_s1 == '0 && i_out_s2 == '0 && i_out_s3 == '0))
        else $error("packed word and samples both nonzero");

    // A stalled result beat holds its offset, packed word, last flag and outer samples
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_offset) && $stable(i_out_packed) &&
         $stable(i_out_last) && $stable(i_out_s0) && $stable(i_out_s3)))
        else $error("stalled result beat changed");

endmodule

bind packet_block_nibble_unpacker_unit pbnu_checker u_pbnu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_offset (o_out.byte_offset),
    .i_out_s0     (o_out.sample_zero),
    .i_out_s1     (o_out.sample_one),
    .i_out_s2     (o_out.sample_two),
    .i_out_s3     (o_out.sample_three),
    .i_out_packed (o_out.packed_word),
    .i_out_last   (o_out.block_last)
);

`default_nettype wire
